@@ rtl/ebs_pkg.sv @@
`default_nettype none

package ebs_pkg;

  localparam int DEF_MAX_RATES = 16;
  localparam int DEF_MAX_CONNS = 8;

  localparam int MODE_W  = 2;
  localparam int CONN_W  = 3;
  localparam int IDX_W   = 4;
  localparam int RATE_W  = 16;
  localparam int BYTES_W = 32;
  localparam int US_W    = 32;
  localparam int KBPS_W  = 32;
  localparam int ALPHA_W = 9;

  localparam int SCALE_W = 13;
  localparam int PROD_W  = BYTES_W + SCALE_W;
  localparam int EWMA_W  = KBPS_W + ALPHA_W;

  localparam int DIV_STEPS = 32;

  typedef logic [MODE_W-1:0]  mode_t;
  typedef logic [CONN_W-1:0]  conn_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [RATE_W-1:0]  rate_t;
  typedef logic [KBPS_W-1:0]  kbps_t;
  typedef logic [ALPHA_W-1:0] alpha_t;

  localparam mode_t MODE_OPEN    = 2'd0;
  localparam mode_t MODE_LOAD    = 2'd1;
  localparam mode_t MODE_SELECT  = 2'd2;
  localparam mode_t MODE_MEASURE = 2'd3;

  localparam kbps_t  INIT_ESTIMATE = 32'd10;
  localparam kbps_t  SAT_KBPS      = 32'hFFFF_FFFF;
  localparam alpha_t ALPHA_ONE     = 9'd256;
  localparam alpha_t ALPHA_RESET   = 9'd128;
  localparam logic [SCALE_W-1:0] KBPS_SCALE = 13'd8000;

  typedef struct packed {
    logic cap;
    logic est_ld;
    logic tbl_wr;
    logic t0_ld;
    logic scan_cmp;
    logic mul;
    logic div_init;
    logic div_step;
    logic ewma_mul;
    logic ewma_add;
    logic est_wb;
    logic out_ld;
  } dp_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  last_entry;
    logic  scan_done;
    logic  div_sat;
  } dp_sts_t;

endpackage

`default_nettype wire

@@ rtl/ebs_req_if.sv @@
`default_nettype none

interface ebs_req_if import ebs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  mode_t                mode;
  conn_t                conn;
  idx_t                 entry_index;
  rate_t                rate_kbps;
  logic                 last_entry;
  logic [BYTES_W-1:0]   chunk_bytes;
  logic [US_W-1:0]      elapsed_us;

  modport source (
    output valid, mode, conn, entry_index, rate_kbps, last_entry, chunk_bytes, elapsed_us,
    input  ready
  );

  modport sink (
    input  valid, mode, conn, entry_index, rate_kbps, last_entry, chunk_bytes, elapsed_us,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/ebs_rsp_if.sv @@
`default_nettype none

interface ebs_rsp_if import ebs_pkg::*; ();
  logic  valid;
  logic  ready;
  rate_t chosen_rate;
  kbps_t throughput_kbps;
  kbps_t estimate_kbps;

  modport source (
    output valid, chosen_rate, throughput_kbps, estimate_kbps,
    input  ready
  );

  modport sink (
    input  valid, chosen_rate, throughput_kbps, estimate_kbps,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/ebs_ram.sv @@
`default_nettype none

module ebs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ rtl/ebs_dp.sv @@
`default_nettype none

module ebs_dp import ebs_pkg::*; #(
  parameter int MAX_RATES = DEF_MAX_RATES,
  parameter int MAX_CONNS = DEF_MAX_CONNS,
  localparam int CNT_W    = ($clog2(MAX_RATES + 1) > 6) ? $clog2(MAX_RATES + 1) : 6
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire alpha_t             cfg_wr_data,
  input  wire mode_t              in_mode,
  input  wire conn_t              in_conn,
  input  wire idx_t               in_entry_index,
  input  wire rate_t              in_rate_kbps,
  input  wire logic               in_last_entry,
  input  wire logic [BYTES_W-1:0] in_chunk_bytes,
  input  wire logic [US_W-1:0]    in_elapsed_us,
  input  wire dp_cmd_t            cmd,
  input  wire logic [CNT_W-1:0]   cnt,
  output dp_sts_t                 sts,
  output rate_t                   out_chosen_rate,
  output kbps_t                   out_throughput_kbps,
  output kbps_t                   out_estimate_kbps
);

  localparam int RATE_AW = (MAX_RATES > 1) ? $clog2(MAX_RATES) : 1;
  localparam int CONN_AW = (MAX_CONNS > 1) ? $clog2(MAX_CONNS) : 1;
  localparam int RC_W    = $clog2(MAX_RATES + 1);

  alpha_t              alpha_r;
  mode_t               mode_r;
  logic [6:0]          conn_ext_r;
  logic [6:0]          idx_ext_r;
  logic                conn_ok_r;
  logic                idx_ok_r;
  rate_t               rate_r;
  logic                last_r;
  logic [BYTES_W-1:0]  bytes_r;
  logic [US_W-1:0]     us_r;

  kbps_t               est_r;
  kbps_t               tput_r;
  rate_t               chosen_r;
  rate_t               prev_r;
  logic [RC_W-1:0]     rc_r;
  logic [MAX_RATES-1:0] tbl_vld_r;
  logic [MAX_CONNS-1:0] est_vld_r;
  logic                tbl_rvld_r;
  logic                est_rvld_r;
  logic [PROD_W-1:0]   prod_r;
  logic [US_W-1:0]     rem_r;
  logic [BYTES_W-1:0]  dl_r;
  logic [EWMA_W-1:0]   p1_r;
  logic [EWMA_W-1:0]   p2_r;

  logic [CONN_AW-1:0]  conn_a;
  logic [RATE_AW-1:0]  idx_a;
  logic [RATE_AW-1:0]  scan_a;
  rate_t               tbl_q;
  kbps_t               est_q;
  rate_t               entry;
  kbps_t               est_rd;
  logic [RATE_W+1:0]   entry_x3;
  logic                exceed;
  logic                n_zero;
  logic                at_end;
  logic [CNT_W-1:0]    cnt_p1;
  logic [IDX_W:0]      idx_p1;
  logic [US_W:0]       div_t;
  logic                div_ge;
  alpha_t              alpha_lim;
  logic [EWMA_W-1:0]   ewma_sum;

  assign conn_a   = conn_ext_r[CONN_AW-1:0];
  assign idx_a    = idx_ext_r[RATE_AW-1:0];
  assign scan_a   = cnt[RATE_AW-1:0];
  assign entry    = tbl_rvld_r ? tbl_q : '0;
  assign est_rd   = est_rvld_r ? est_q : INIT_ESTIMATE;
  assign entry_x3 = {1'b0, entry, 1'b0} + {2'b00, entry};
  assign exceed   = (33'(entry_x3) > {est_r, 1'b0});
  assign n_zero   = (rc_r == '0);
  assign cnt_p1   = cnt + CNT_W'(1);
  assign at_end   = (cnt_p1 == CNT_W'(rc_r));
  assign idx_p1   = {1'b0, idx_ext_r[IDX_W-1:0]} + (IDX_W+1)'(1);
  assign div_t    = {rem_r, dl_r[BYTES_W-1]};
  assign div_ge   = (div_t >= {1'b0, us_r});
  assign alpha_lim = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;
  assign ewma_sum = p1_r + p2_r;

  assign sts.mode       = mode_r;
  assign sts.last_entry = last_r;
  assign sts.scan_done  = n_zero || exceed || at_end;
  assign sts.div_sat    = ({19'b0, prod_r[PROD_W-1:KBPS_W]} >= us_r);

  ebs_ram #(.WIDTH(RATE_W), .DEPTH(MAX_RATES)) u_tbl_ram (
    .clk     (clk),
    .wr_en   (cmd.tbl_wr && idx_ok_r),
    .wr_addr (idx_a),
    .wr_data (rate_r),
    .rd_addr (scan_a),
    .rd_data (tbl_q)
  );

  ebs_ram #(.WIDTH(KBPS_W), .DEPTH(MAX_CONNS)) u_est_ram (
    .clk     (clk),
    .wr_en   (cmd.est_wb && conn_ok_r),
    .wr_addr (conn_a),
    .wr_data (est_r),
    .rd_addr (conn_a),
    .rd_data (est_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r   <= ALPHA_RESET;
      rc_r      <= '0;
      tbl_vld_r <= '0;
      est_vld_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        alpha_r <= cfg_wr_data;
      end
      if (cmd.tbl_wr) begin
        if (idx_ok_r) begin
          tbl_vld_r[idx_a] <= 1'b1;
        end
        if (last_r) begin
          if (32'(idx_p1) > 32'(MAX_RATES)) begin
            rc_r <= RC_W'(MAX_RATES);
          end else begin
            rc_r <= RC_W'(idx_p1);
          end
        end
      end
      if (cmd.est_wb && conn_ok_r) begin
        est_vld_r[conn_a] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    tbl_rvld_r <= tbl_vld_r[scan_a];
    est_rvld_r <= est_vld_r[conn_a];

    if (cmd.cap) begin
      mode_r     <= in_mode;
      conn_ext_r <= 7'(in_conn);
      idx_ext_r  <= 7'(in_entry_index);
      conn_ok_r  <= (32'(in_conn) < 32'(MAX_CONNS));
      idx_ok_r   <= (32'(in_entry_index) < 32'(MAX_RATES));
      rate_r     <= in_rate_kbps;
      last_r     <= in_last_entry;
      bytes_r    <= in_chunk_bytes;
      us_r       <= in_elapsed_us;
    end

    if (cmd.est_ld) begin
      chosen_r <= '0;
      tput_r   <= '0;
      if (mode_r == MODE_OPEN) begin
        est_r <= INIT_ESTIMATE;
      end else begin
        est_r <= conn_ok_r ? est_rd : '0;
      end
    end

    if (cmd.t0_ld) begin
      est_r <= KBPS_W'(entry);
    end

    if (cmd.scan_cmp) begin
      prev_r   <= entry;
      chosen_r <= (n_zero || !exceed || (cnt == '0)) ? entry : prev_r;
    end

    if (cmd.mul) begin
      prod_r <= PROD_W'(bytes_r) * PROD_W'(KBPS_SCALE);
    end

    if (cmd.div_init) begin
      rem_r  <= US_W'(prod_r[PROD_W-1:KBPS_W]);
      dl_r   <= prod_r[KBPS_W-1:0];
      tput_r <= sts.div_sat ? SAT_KBPS : '0;
    end

    if (cmd.div_step) begin
      rem_r  <= div_ge ? US_W'(div_t - {1'b0, us_r}) : div_t[US_W-1:0];
      dl_r   <= {dl_r[BYTES_W-2:0], 1'b0};
      tput_r <= {tput_r[KBPS_W-2:0], div_ge};
    end

    if (cmd.ewma_mul) begin
      p1_r <= EWMA_W'(tput_r) * EWMA_W'(alpha_lim);
      p2_r <= EWMA_W'(est_r) * EWMA_W'(ALPHA_ONE - alpha_lim);
    end

    if (cmd.ewma_add) begin
      est_r <= ewma_sum[KBPS_W+7:8];
    end

    if (cmd.out_ld) begin
      out_chosen_rate     <= chosen_r;
      out_throughput_kbps <= tput_r;
      out_estimate_kbps   <= conn_ok_r ? est_r : '0;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ebs_ctrl.sv @@
`default_nettype none

module ebs_ctrl import ebs_pkg::*; #(
  parameter int MAX_RATES = DEF_MAX_RATES,
  localparam int CNT_W    = ($clog2(MAX_RATES + 1) > 6) ? $clog2(MAX_RATES + 1) : 6
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire dp_sts_t          sts,
  output dp_cmd_t               cmd,
  output logic      [CNT_W-1:0] cnt
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_EST_RD   = 4'd1;
  localparam logic [3:0] S_EST_LD   = 4'd2;
  localparam logic [3:0] S_TBL_WR   = 4'd3;
  localparam logic [3:0] S_T0_RD    = 4'd4;
  localparam logic [3:0] S_T0_LD    = 4'd5;
  localparam logic [3:0] S_SC_RD    = 4'd6;
  localparam logic [3:0] S_SC_CMP   = 4'd7;
  localparam logic [3:0] S_MUL      = 4'd8;
  localparam logic [3:0] S_DIV_INIT = 4'd9;
  localparam logic [3:0] S_DIV      = 4'd10;
  localparam logic [3:0] S_EW_MUL   = 4'd11;
  localparam logic [3:0] S_EW_ADD   = 4'd12;
  localparam logic [3:0] S_WB       = 4'd13;
  localparam logic [3:0] S_FIN      = 4'd14;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_vld_r, out_vld_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_vld_r;
  assign cnt       = cnt_r;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    out_vld_nxt = out_vld_r && !out_ready;
    cmd         = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_EST_RD;
        end
      end
      S_EST_RD: begin
        state_nxt = S_EST_LD;
      end
      S_EST_LD: begin
        cmd.est_ld = 1'b1;
        cnt_nxt    = '0;
        unique case (sts.mode)
          MODE_OPEN:    state_nxt = S_WB;
          MODE_LOAD:    state_nxt = S_TBL_WR;
          MODE_SELECT:  state_nxt = S_SC_RD;
          MODE_MEASURE: state_nxt = S_MUL;
          default:      state_nxt = S_WB;
        endcase
      end
      S_TBL_WR: begin
        cmd.tbl_wr = 1'b1;
        state_nxt  = sts.last_entry ? S_T0_RD : S_WB;
      end
      S_T0_RD: begin
        state_nxt = S_T0_LD;
      end
      S_T0_LD: begin
        cmd.t0_ld = 1'b1;
        state_nxt = S_WB;
      end
      S_SC_RD: begin
        state_nxt = S_SC_CMP;
      end
      S_SC_CMP: begin
        cmd.scan_cmp = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_WB;
        end else begin
          cnt_nxt   = cnt_r + CNT_W'(1);
          state_nxt = S_SC_RD;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = sts.div_sat ? S_EW_MUL : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_EW_MUL;
        end
      end
      S_EW_MUL: begin
        cmd.ewma_mul = 1'b1;
        state_nxt    = S_EW_ADD;
      end
      S_EW_ADD: begin
        cmd.ewma_add = 1'b1;
        state_nxt    = S_WB;
      end
      S_WB: begin
        cmd.est_wb = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (!out_vld_r || out_ready) begin
          cmd.out_ld  = 1'b1;
          out_vld_nxt = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ewma_throughput_bitrate_selector.sv @@
`default_nettype none

// Throughput-based adaptive bitrate selector. Each transfer on in_if carries one
// operation chosen by mode: open (reset a connection's estimate to 10 kbps), load
// (write one entry of the ascending rate table; the last entry sets the table size
// and seeds that connection's estimate with entry 0), select (largest rate not above
// estimate/1.5, else entry 0) and measure (bytes*8000/elapsed_us kbps, saturated,
// folded into the estimate with weight alpha_q8/256 written on cfg_wr_en/cfg_wr_data).
// Every operation returns exactly one transfer on out_if. Items are handled one at a
// time: select examines table entries in index order until one lies above the margin
// or the table ends, and measure forms the quotient with the 32-step restoring divider;
// a measure whose quotient saturates skips the divider. The result register frees the
// input side, so the next item is taken while a result still waits; that item then
// holds in its final state until the waiting result is accepted. No clearing pass
// runs after reset;
// write alpha only while the block is idle.
module ewma_throughput_bitrate_selector import ebs_pkg::*; #(
  parameter int MAX_RATES = DEF_MAX_RATES,
  parameter int MAX_CONNS = DEF_MAX_CONNS
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   cfg_wr_en,
  input  wire alpha_t cfg_wr_data,
  ebs_req_if.sink     in_if,
  ebs_rsp_if.source   out_if
);

  localparam int CNT_W = ($clog2(MAX_RATES + 1) > 6) ? $clog2(MAX_RATES + 1) : 6;

  dp_cmd_t          cmd;
  dp_sts_t          sts;
  logic [CNT_W-1:0] cnt;

  ebs_ctrl #(.MAX_RATES(MAX_RATES)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd),
    .cnt       (cnt)
  );

  ebs_dp #(.MAX_RATES(MAX_RATES), .MAX_CONNS(MAX_CONNS)) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_mode             (in_if.mode),
    .in_conn             (in_if.conn),
    .in_entry_index      (in_if.entry_index),
    .in_rate_kbps        (in_if.rate_kbps),
    .in_last_entry       (in_if.last_entry),
    .in_chunk_bytes      (in_if.chunk_bytes),
    .in_elapsed_us       (in_if.elapsed_us),
    .cmd                 (cmd),
    .cnt                 (cnt),
    .sts                 (sts),
    .out_chosen_rate     (out_if.chosen_rate),
    .out_throughput_kbps (out_if.throughput_kbps),
    .out_estimate_kbps   (out_if.estimate_kbps)
  );

endmodule

`default_nettype wire

@@ test/tb_ewma_throughput_bitrate_selector.sv @@
`default_nettype none

module tb_ewma_throughput_bitrate_selector;
  import ebs_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    mode_t              mode;
    conn_t              conn;
    idx_t               entry_index;
    rate_t              rate_kbps;
    logic               last_entry;
    logic [BYTES_W-1:0] chunk_bytes;
    logic [US_W-1:0]    elapsed_us;
  } abr_req_t;

  typedef struct packed {
    rate_t chosen;
    kbps_t tput;
    kbps_t est;
  } abr_result_t;

  logic   clk;
  logic   rst_n;
  logic   cfg_wr_en;
  alpha_t cfg_wr_data;

  ebs_req_if in_ch ();
  ebs_rsp_if out_ch ();

  ewma_throughput_bitrate_selector u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_if       (in_ch),
    .out_if      (out_ch)
  );

  rate_t       tbl_rate [DEF_MAX_RATES];
  int          tbl_len;
  kbps_t       conn_est [DEF_MAX_CONNS];
  alpha_t      alpha_w;
  abr_result_t pending_results [$];
  int          errors;
  int          quiet_cycles;
  bit          tx_quiet;
  bit          rx_quiet;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit rate_above_margin(rate_t r, kbps_t e);
    logic [63:0] lhs;
    logic [63:0] rhs;
    lhs = 64'(r) * 64'd3;
    rhs = 64'(e) * 64'd2;
    return lhs > rhs;
  endfunction

  function automatic rate_t pick_covered_rate(kbps_t e);
    int n;
    n = tbl_len;
    if (n > DEF_MAX_RATES) n = DEF_MAX_RATES;
    if (n == 0 || rate_above_margin(tbl_rate[0], e)) return tbl_rate[0];
    for (int i = 1; i < n; i++) begin
      if (rate_above_margin(tbl_rate[i], e)) return tbl_rate[i-1];
    end
    return tbl_rate[n-1];
  endfunction

  function automatic kbps_t chunk_kbps(logic [BYTES_W-1:0] b, logic [US_W-1:0] us);
    logic [63:0] q;
    if (us == '0) return SAT_KBPS;
    q = (64'(b) * 64'(KBPS_SCALE)) / 64'(us);
    if (q > 64'(SAT_KBPS)) return SAT_KBPS;
    return q[31:0];
  endfunction

  function automatic abr_result_t next_abr_result(abr_req_t it);
    abr_result_t r;
    kbps_t       e;
    alpha_t      a;
    alpha_t      inv;
    logic [63:0] acc;
    r = '0;
    e = conn_est[it.conn];
    case (it.mode)
      MODE_OPEN: begin
        e = INIT_ESTIMATE;
      end
      MODE_LOAD: begin
        tbl_rate[it.entry_index] = it.rate_kbps;
        if (it.last_entry) begin
          tbl_len = int'(it.entry_index) + 1;
          e = kbps_t'(tbl_rate[0]);
        end
      end
      MODE_SELECT: begin
        r.chosen = pick_covered_rate(e);
      end
      default: begin
        a = (alpha_w > ALPHA_ONE) ? ALPHA_ONE : alpha_w;
        inv = ALPHA_ONE - a;
        r.tput = chunk_kbps(it.chunk_bytes, it.elapsed_us);
        acc = 64'(r.tput) * 64'(a) + 64'(e) * 64'(inv);
        e = acc[39:8];
      end
    endcase
    conn_est[it.conn] = e;
    r.est = e;
    return r;
  endfunction

  function automatic int pick_idle(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 120);
  endfunction

  function automatic abr_req_t random_item();
    abr_req_t it;
    it.mode        = mode_t'($urandom);
    it.conn        = conn_t'($urandom);
    it.entry_index = idx_t'($urandom);
    it.rate_kbps   = rate_t'($urandom);
    it.last_entry  = 1'($urandom);
    it.chunk_bytes = $urandom;
    it.elapsed_us  = $urandom;
    return it;
  endfunction

  function automatic abr_req_t op_item(mode_t m, conn_t c);
    abr_req_t it;
    it = random_item();
    it.mode = m;
    it.conn = c;
    return it;
  endfunction

  // receiver stalls
  initial begin : rx_ready_gen
    int stall;
    stall = 0;
    rx_quiet = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 199) == 0) rx_quiet = ~rx_quiet;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        stall = pick_idle(rx_quiet);
      end
    end
  end

  always @(posedge clk) begin : transfer_mon
    abr_req_t    got_req;
    abr_result_t want;
    if (rst_n) begin
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        got_req.mode        = in_ch.mode;
        got_req.conn        = in_ch.conn;
        got_req.entry_index = in_ch.entry_index;
        got_req.rate_kbps   = in_ch.rate_kbps;
        got_req.last_entry  = in_ch.last_entry;
        got_req.chunk_bytes = in_ch.chunk_bytes;
        got_req.elapsed_us  = in_ch.elapsed_us;
        pending_results.push_back(next_abr_result(got_req));
      end
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result chosen %0d tput %0d est %0d", $time,
                   out_ch.chosen_rate, out_ch.throughput_kbps, out_ch.estimate_kbps);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_ch.chosen_rate !== want.chosen) begin
            $display("%0t: chosen_rate expected %0d actual %0d", $time,
                     want.chosen, out_ch.chosen_rate);
            errors++;
          end
          if (out_ch.throughput_kbps !== want.tput) begin
            $display("%0t: throughput_kbps expected %0d actual %0d", $time,
                     want.tput, out_ch.throughput_kbps);
            errors++;
          end
          if (out_ch.estimate_kbps !== want.est) begin
            $display("%0t: estimate_kbps expected %0d actual %0d", $time,
                     want.est, out_ch.estimate_kbps);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("** ewma_throughput_bitrate_selector: FAILED **");
      $finish;
    end
  end

  task automatic send_item(abr_req_t it);
    int gap;
    if ($urandom_range(0, 59) == 0) tx_quiet = ~tx_quiet;
    gap = pick_idle(tx_quiet);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= it.mode;
    in_ch.conn        <= it.conn;
    in_ch.entry_index <= it.entry_index;
    in_ch.rate_kbps   <= it.rate_kbps;
    in_ch.last_entry  <= it.last_entry;
    in_ch.chunk_bytes <= it.chunk_bytes;
    in_ch.elapsed_us  <= it.elapsed_us;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_alpha(alpha_t v);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    alpha_w = v;
  endtask

  task automatic send_measure(conn_t c, logic [BYTES_W-1:0] b, logic [US_W-1:0] us);
    abr_req_t it;
    it = op_item(MODE_MEASURE, c);
    it.chunk_bytes = b;
    it.elapsed_us  = us;
    send_item(it);
  endtask

  task automatic send_load(conn_t c, idx_t idx, rate_t r, logic last);
    abr_req_t it;
    it = op_item(MODE_LOAD, c);
    it.entry_index = idx;
    it.rate_kbps   = r;
    it.last_entry  = last;
    send_item(it);
  endtask

  task automatic test_empty_table();
    send_item(op_item(MODE_SELECT, 3'd0));
    send_item(op_item(MODE_OPEN, 3'd7));
    send_item(op_item(MODE_SELECT, 3'd7));
  endtask

  task automatic test_manifest_select();
    send_load(3'd3, 4'd0, 16'd300, 1'b0);
    send_load(3'd3, 4'd1, 16'd750, 1'b0);
    send_load(3'd3, 4'd2, 16'd1200, 1'b0);
    send_load(3'd3, 4'd3, 16'd2500, 1'b1);
    send_item(op_item(MODE_SELECT, 3'd3));
    send_measure(3'd3, 32'd1_000_000, 32'd1_000_000);
    send_item(op_item(MODE_SELECT, 3'd3));
  endtask

  task automatic test_saturation();
    send_measure(3'd1, 32'd0, 32'd0);
    send_measure(3'd2, 32'd123_456, 32'd0);
    send_measure(3'd4, 32'hFFFF_FFFF, 32'd1);
    send_measure(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_measure(3'd6, 32'd1, 32'd8001);
    send_item(op_item(MODE_SELECT, 3'd4));
  endtask

  task automatic test_table_extremes();
    send_load(3'd0, 4'd0, 16'd0, 1'b0);
    send_load(3'd7, 4'd15, 16'hFFFF, 1'b1);
    send_item(op_item(MODE_SELECT, 3'd7));
    send_item(op_item(MODE_SELECT, 3'd4));
  endtask

  task automatic test_alpha_extremes();
    write_alpha(9'd0);
    send_measure(3'd2, 32'd500_000, 32'd400_000);
    write_alpha(ALPHA_ONE);
    send_measure(3'd2, 32'd500_000, 32'd400_000);
    write_alpha(9'h1FF);
    send_measure(3'd2, 32'd700_000, 32'd900_000);
    write_alpha(9'd1);
    send_measure(3'd2, 32'hFFFF_FFFF, 32'd3);
    write_alpha(9'd255);
    send_measure(3'd2, 32'd0, 32'd1);
  endtask

  task automatic send_manifest(output int n_sent);
    int       n;
    int       r;
    abr_req_t it;
    conn_t    c;
    n = ($urandom_range(0, 3) == 0) ? DEF_MAX_RATES : $urandom_range(1, 8);
    r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 1500);
    c = conn_t'($urandom);
    for (int i = 0; i < n; i++) begin
      it = op_item(MODE_LOAD, c);
      it.entry_index = idx_t'(i);
      it.rate_kbps   = rate_t'(r);
      it.last_entry  = (i == n - 1);
      // broken manifest: stray or missing last marker
      if ($urandom_range(0, 19) == 0) it.last_entry = ~it.last_entry;
      send_item(it);
      r = r + $urandom_range(1, 8000);
      if (r > 65535) r = 65535;
    end
    n_sent = n;
  endtask

  task automatic send_chunk(conn_t c);
    abr_req_t it;
    it = op_item(MODE_MEASURE, c);
    case ($urandom_range(0, 9))
      0: it.elapsed_us = '0;
      1: it.elapsed_us = $urandom_range(1, 16);
      2: ;
      default: begin
        it.chunk_bytes = $urandom_range(0, 4_000_000);
        it.elapsed_us  = $urandom_range(1, 4_000_000);
      end
    endcase
    send_item(it);
  endtask

  task automatic test_random_traffic(int n_items);
    int    sent;
    int    pick;
    int    n;
    conn_t c;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      c = conn_t'($urandom);
      if (pick < 12) begin
        send_manifest(n);
        sent += n;
      end else if (pick < 40) begin
        send_chunk(c);
        sent++;
      end else if (pick < 62) begin
        send_item(op_item(MODE_SELECT, c));
        sent++;
      end else if (pick < 70) begin
        send_item(op_item(MODE_OPEN, c));
        sent++;
      end else if (pick < 90) begin
        send_chunk(c);
        send_item(op_item(MODE_SELECT, c));
        sent += 2;
      end else begin
        send_item(random_item());
        sent++;
      end
    end
  endtask

  initial begin
    rst_n             <= 1'b0;
    cfg_wr_en         <= 1'b0;
    cfg_wr_data       <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.mode        <= MODE_OPEN;
    in_ch.conn        <= '0;
    in_ch.entry_index <= '0;
    in_ch.rate_kbps   <= '0;
    in_ch.last_entry  <= 1'b0;
    in_ch.chunk_bytes <= '0;
    in_ch.elapsed_us  <= '0;
    errors       = 0;
    quiet_cycles = 0;
    tx_quiet     = 1'b0;
    alpha_w      = ALPHA_RESET;
    tbl_len      = 0;
    foreach (tbl_rate[i]) tbl_rate[i] = '0;
    foreach (conn_est[i]) conn_est[i] = INIT_ESTIMATE;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_manifest_select();
    test_saturation();
    test_table_extremes();
    test_alpha_extremes();

    write_alpha(9'd64);
    test_random_traffic(400);
    write_alpha(alpha_t'($urandom_range(0, 511)));
    test_random_traffic(400);
    write_alpha(ALPHA_ONE);
    test_random_traffic(400);
    write_alpha(alpha_t'($urandom_range(1, 255)));
    test_random_traffic(400);

    wait_idle();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("** ewma_throughput_bitrate_selector: PASSED **");
    end else begin
      $display("** ewma_throughput_bitrate_selector: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
